/* design/wtsp_pkg.sv */
package wtsp_pkg;

   // field and datapath widths
   localparam int COORD_W  = 32;
   localparam int COEF_W   = 24;
   localparam int FRAC_W   = 16;
   localparam int SIZE_W   = 14;
   localparam int PIX_W    = 16;
   localparam int SUM_W    = COORD_W + 1;
   localparam int PROD_W   = SUM_W + COEF_W;
   localparam int DOT_W    = PROD_W + 18;
   localparam int NUM_W    = DOT_W + 1 + SIZE_W;
   localparam int REM_W    = NUM_W + 2;
   localparam int QUO_W    = 16;
   localparam int REG_W    = 2 * COEF_W;

   // visibility threshold, Q16.16 (0.001)
   localparam int VIS_THRESH_Q16 = 66;

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   // queue depths (powers of two)
   localparam int MID_DEPTH = 8;
   localparam int OUT_DEPTH = 32;

   typedef enum logic [2:0] {
      REG_ROW0_XY = 3'd0,
      REG_ROW0_ZW = 3'd1,
      REG_ROW1_XY = 3'd2,
      REG_ROW1_ZW = 3'd3,
      REG_ROW3_XY = 3'd4,
      REG_ROW3_ZW = 3'd5,
      REG_WIDTH   = 3'd6,
      REG_HEIGHT  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] off_x;
      logic signed [COORD_W-1:0] off_y;
      logic signed [COORD_W-1:0] off_z;
   } req_word_type;

   typedef struct packed {
      logic                    on_screen;
      logic signed [PIX_W-1:0] screen_x;
      logic signed [PIX_W-1:0] screen_y;
   } rsp_word_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] c3;
      logic signed [COEF_W-1:0] c2;
      logic signed [COEF_W-1:0] c1;
      logic signed [COEF_W-1:0] c0;
   } row_type;

   typedef struct packed {
      row_type r3;
      row_type r1;
      row_type r0;
   } matrix_type;

   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } viewport_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] w;
      logic signed [DOT_W-1:0] sx;
      logic signed [DOT_W-1:0] sy;
   } clip_type;

endpackage

/* design/wtsp_fifo.sv */
module wtsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] data_out
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   // space is guaranteed by the caller's credit count
   assign do_pop    = pop && (count_ff != '0);
   assign wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

   assign empty    = (count_ff == '0);
   assign data_out = mem_ff[rd_ptr_ff];

endmodule

/* design/wtsp_front.sv */
module wtsp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  wtsp_pkg::req_word_type in_word,
   input  wtsp_pkg::matrix_type  matrix,
   output logic                  out_valid,
   output wtsp_pkg::clip_type    out_clip
);

   localparam int SUM_W  = wtsp_pkg::SUM_W;
   localparam int PROD_W = wtsp_pkg::PROD_W;
   localparam int DOT_W  = wtsp_pkg::DOT_W;

   wtsp_pkg::row_type rows [3];

   logic [2:0] valid_ff;

   logic signed [SUM_W-1:0]  x_ff, y_ff, z_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [DOT_W-1:0]  dot     [3];

   assign rows[0] = matrix.r0;
   assign rows[1] = matrix.r1;
   assign rows[2] = matrix.r3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // stage 1: point plus offset, exact
   always_ff @(posedge clock) begin
      x_ff <= SUM_W'(in_word.pos_x) + SUM_W'(in_word.off_x);
      y_ff <= SUM_W'(in_word.pos_y) + SUM_W'(in_word.off_y);
      z_ff <= SUM_W'(in_word.pos_z) + SUM_W'(in_word.off_z);
   end

   // stage 2: nine products
   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         prod_ff[r][0] <= PROD_W'(rows[r].c0) * PROD_W'(x_ff);
         prod_ff[r][1] <= PROD_W'(rows[r].c1) * PROD_W'(y_ff);
         prod_ff[r][2] <= PROD_W'(rows[r].c2) * PROD_W'(z_ff);
      end
   end

   // stage 3: row sums; coefficient 3 times 1.0 lands at 32 fraction bits
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         dot[r] = DOT_W'(prod_ff[r][0]) + DOT_W'(prod_ff[r][1])
                + DOT_W'(prod_ff[r][2])
                + (DOT_W'(rows[r].c3) <<< wtsp_pkg::FRAC_W);
      end
   end

   always_ff @(posedge clock) begin
      out_clip.sx <= dot[0];
      out_clip.sy <= dot[1];
      out_clip.w  <= dot[2];
   end

   assign out_valid = valid_ff[2];

endmodule

/* design/wtsp_back.sv */
module wtsp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  wtsp_pkg::clip_type     in_clip,
   input  wtsp_pkg::viewport_type viewport,
   output logic                   out_valid,
   output wtsp_pkg::rsp_word_type out_word
);

   localparam int DOT_W = wtsp_pkg::DOT_W;
   localparam int N_W   = DOT_W + 1;
   localparam int NUM_W = wtsp_pkg::NUM_W;
   localparam int REM_W = wtsp_pkg::REM_W;
   localparam int QUO_W = wtsp_pkg::QUO_W;
   localparam int PIX_W = wtsp_pkg::PIX_W;

   localparam logic signed [DOT_W-1:0] THRESH =
      DOT_W'(wtsp_pkg::VIS_THRESH_Q16) <<< wtsp_pkg::FRAC_W;
   localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_MAX = {1'b1, {(QUO_W-1){1'b0}}};

   logic [2:0]       pre_valid_ff;
   logic [QUO_W+1:0] div_valid_ff;

   // stage 1
   logic signed [N_W-1:0] n_ff [2];
   logic [N_W-1:0]        d1_ff;
   logic                  vis1_ff;
   // stage 2
   logic [N_W-1:0]        mag_ff [2];
   logic                  neg2_ff [2];
   logic [N_W-1:0]        d2_ff;
   logic                  vis2_ff;
   // stage 3
   logic [NUM_W-1:0]      num_ff [2];
   logic                  neg3_ff [2];
   logic [N_W-1:0]        d3_ff;
   logic                  vis3_ff;
   // divider stages, index 0 is the range check
   logic [REM_W-1:0]      rem_ff [QUO_W+1][2];
   logic [QUO_W-1:0]      quo_ff [QUO_W+1][2];
   logic                  big_ff [QUO_W+1][2];
   logic                  neg_ff [QUO_W+1][2];
   logic [N_W-1:0]        d_ff   [QUO_W+1];
   logic                  vis_ff [QUO_W+1];

   logic [PIX_W-1:0]      pix [2];
   logic [wtsp_pkg::SIZE_W-1:0] size [2];

   assign size[0] = viewport.width;
   assign size[1] = viewport.height;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= '0;
         div_valid_ff <= '0;
      end else begin
         pre_valid_ff <= {pre_valid_ff[1:0], in_valid};
         div_valid_ff <= {div_valid_ff[QUO_W:0], pre_valid_ff[2]};
      end
   end

   always_ff @(posedge clock) begin
      // numerators w+sx and w-sy, divisor 2w
      n_ff[0] <= N_W'(in_clip.w) + N_W'(in_clip.sx);
      n_ff[1] <= N_W'(in_clip.w) - N_W'(in_clip.sy);
      d1_ff   <= $unsigned(N_W'(in_clip.w) <<< 1);
      vis1_ff <= (in_clip.w > THRESH);

      for (int l = 0; l < 2; l++) begin
         neg2_ff[l] <= n_ff[l][N_W-1];
         mag_ff[l]  <= $unsigned(n_ff[l][N_W-1] ? -n_ff[l] : n_ff[l]);
      end
      d2_ff   <= d1_ff;
      vis2_ff <= vis1_ff;

      for (int l = 0; l < 2; l++) begin
         num_ff[l]  <= NUM_W'(mag_ff[l]) * NUM_W'(size[l]);
         neg3_ff[l] <= neg2_ff[l];
      end
      d3_ff   <= d2_ff;
      vis3_ff <= vis2_ff;

      // quotient of 2^16 or more saturates either way
      for (int l = 0; l < 2; l++) begin
         rem_ff[0][l] <= REM_W'(num_ff[l]);
         quo_ff[0][l] <= '0;
         big_ff[0][l] <= (REM_W'(num_ff[l]) >= (REM_W'(d3_ff) << QUO_W));
         neg_ff[0][l] <= neg3_ff[l];
      end
      d_ff[0]   <= d3_ff;
      vis_ff[0] <= vis3_ff;

      // restoring division, one quotient bit per stage
      for (int s = 0; s < QUO_W; s++) begin
         for (int l = 0; l < 2; l++) begin
            if (rem_ff[s][l] >= (REM_W'(d_ff[s]) << (QUO_W - 1 - s))) begin
               rem_ff[s+1][l] <= rem_ff[s][l] - (REM_W'(d_ff[s]) << (QUO_W - 1 - s));
               quo_ff[s+1][l] <= quo_ff[s][l] | (QUO_W'(1) << (QUO_W - 1 - s));
            end else begin
               rem_ff[s+1][l] <= rem_ff[s][l];
               quo_ff[s+1][l] <= quo_ff[s][l];
            end
            big_ff[s+1][l] <= big_ff[s][l];
            neg_ff[s+1][l] <= neg_ff[s][l];
         end
         d_ff[s+1]   <= d_ff[s];
         vis_ff[s+1] <= vis_ff[s];
      end
   end

   // truncate toward zero, saturate to 16 bits
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (neg_ff[QUO_W][l]) begin
            if (big_ff[QUO_W][l] || (quo_ff[QUO_W][l] > NEG_MAX)) begin
               pix[l] = NEG_MAX;
            end else begin
               pix[l] = PIX_W'(-quo_ff[QUO_W][l]);
            end
         end else begin
            if (big_ff[QUO_W][l] || (quo_ff[QUO_W][l] > POS_MAX)) begin
               pix[l] = POS_MAX;
            end else begin
               pix[l] = PIX_W'(quo_ff[QUO_W][l]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_word.on_screen <= vis_ff[QUO_W];
      out_word.screen_x  <= vis_ff[QUO_W] ? $signed(pix[0]) : '0;
      out_word.screen_y  <= vis_ff[QUO_W] ? $signed(pix[1]) : '0;
   end

   assign out_valid = div_valid_ff[QUO_W+1];

endmodule

/* design/world_to_screen_projection.sv */
// Throughput: one word per cycle while full stays low; set by the pipelined
// multipliers and the 16-stage restoring divider, one quotient bit per stage.
// Reset (synchronous, active high): queues empty, matrix to identity rows,
// viewport to 1920 x 1080.
module world_to_screen_projection (
   input  logic                              clock,
   input  logic                              reset,
   // input queue
   input  logic                              push,
   output logic                              full,
   input  wtsp_pkg::req_word_type            req_word,
   // result queue
   output logic                              empty,
   input  logic                              pop,
   output wtsp_pkg::rsp_word_type            rsp_word,
   // configuration
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [wtsp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [wtsp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [wtsp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int REG_W     = wtsp_pkg::REG_W;
   localparam int COEF_W    = wtsp_pkg::COEF_W;
   localparam int SIZE_W    = wtsp_pkg::SIZE_W;
   localparam int DATA_W    = wtsp_pkg::CSR_DATA_W;
   localparam int MID_DEPTH = wtsp_pkg::MID_DEPTH;
   localparam int OUT_DEPTH = wtsp_pkg::OUT_DEPTH;
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [REG_W-1:0]  row0_xy_ff, row0_zw_ff, row1_xy_ff, row1_zw_ff;
   logic [REG_W-1:0]  row3_xy_ff, row3_zw_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;

   wtsp_pkg::csr_index_type csr_index;
   logic                    csr_write;

   assign csr_index = wtsp_pkg::csr_index_type'(paddr[5:3]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_xy_ff <= REG_W'(1) << wtsp_pkg::FRAC_W;              // m00 = 1.0
         row0_zw_ff <= '0;
         row1_xy_ff <= REG_W'(1) << (wtsp_pkg::FRAC_W + COEF_W);   // m11 = 1.0
         row1_zw_ff <= '0;
         row3_xy_ff <= '0;
         row3_zw_ff <= REG_W'(1) << (wtsp_pkg::FRAC_W + COEF_W);   // m33 = 1.0
         width_ff   <= SIZE_W'(1920);
         height_ff  <= SIZE_W'(1080);
      end else if (csr_write) begin
         case (csr_index)
            wtsp_pkg::REG_ROW0_XY: row0_xy_ff <= pwdata[REG_W-1:0];
            wtsp_pkg::REG_ROW0_ZW: row0_zw_ff <= pwdata[REG_W-1:0];
            wtsp_pkg::REG_ROW1_XY: row1_xy_ff <= pwdata[REG_W-1:0];
            wtsp_pkg::REG_ROW1_ZW: row1_zw_ff <= pwdata[REG_W-1:0];
            wtsp_pkg::REG_ROW3_XY: row3_xy_ff <= pwdata[REG_W-1:0];
            wtsp_pkg::REG_ROW3_ZW: row3_zw_ff <= pwdata[REG_W-1:0];
            wtsp_pkg::REG_WIDTH:   width_ff   <= pwdata[SIZE_W-1:0];
            wtsp_pkg::REG_HEIGHT:  height_ff  <= pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         wtsp_pkg::REG_ROW0_XY: prdata = DATA_W'(row0_xy_ff);
         wtsp_pkg::REG_ROW0_ZW: prdata = DATA_W'(row0_zw_ff);
         wtsp_pkg::REG_ROW1_XY: prdata = DATA_W'(row1_xy_ff);
         wtsp_pkg::REG_ROW1_ZW: prdata = DATA_W'(row1_zw_ff);
         wtsp_pkg::REG_ROW3_XY: prdata = DATA_W'(row3_xy_ff);
         wtsp_pkg::REG_ROW3_ZW: prdata = DATA_W'(row3_zw_ff);
         wtsp_pkg::REG_WIDTH:   prdata = DATA_W'(width_ff);
         wtsp_pkg::REG_HEIGHT:  prdata = DATA_W'(height_ff);
         default:               prdata = '0;
      endcase
   end

   // coefficient unpacking: low half is coefficient 0 or 2
   wtsp_pkg::matrix_type   matrix;
   wtsp_pkg::viewport_type viewport;

   assign matrix.r0 = {row0_zw_ff[REG_W-1:COEF_W], row0_zw_ff[COEF_W-1:0],
                       row0_xy_ff[REG_W-1:COEF_W], row0_xy_ff[COEF_W-1:0]};
   assign matrix.r1 = {row1_zw_ff[REG_W-1:COEF_W], row1_zw_ff[COEF_W-1:0],
                       row1_xy_ff[REG_W-1:COEF_W], row1_xy_ff[COEF_W-1:0]};
   assign matrix.r3 = {row3_zw_ff[REG_W-1:COEF_W], row3_zw_ff[COEF_W-1:0],
                       row3_xy_ff[REG_W-1:COEF_W], row3_xy_ff[COEF_W-1:0]};
   assign viewport.width  = width_ff;
   assign viewport.height = height_ff;

   // ---------------------------------------------------------------
   // flow control by credits: each pipeline never stalls; a word enters
   // only when the queue behind that pipeline is sure to have a slot
   // ---------------------------------------------------------------
   logic                 req_take, mid_take, rsp_take;
   logic [MID_CNT_W-1:0] mid_occ_ff, mid_occ_in;
   logic [OUT_CNT_W-1:0] out_occ_ff, out_occ_in;
   logic                 mid_empty;

   assign full     = (mid_occ_ff == MID_CNT_W'(MID_DEPTH));
   assign req_take = push && !full;
   assign mid_take = !mid_empty && (out_occ_ff != OUT_CNT_W'(OUT_DEPTH));
   assign rsp_take = pop && !empty;

   always_comb begin
      mid_occ_in = mid_occ_ff;
      if (req_take && !mid_take) begin
         mid_occ_in = mid_occ_ff + 1'b1;
      end else if (!req_take && mid_take) begin
         mid_occ_in = mid_occ_ff - 1'b1;
      end
      out_occ_in = out_occ_ff;
      if (mid_take && !rsp_take) begin
         out_occ_in = out_occ_ff + 1'b1;
      end else if (!mid_take && rsp_take) begin
         out_occ_in = out_occ_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_occ_ff <= '0;
         out_occ_ff <= '0;
      end else begin
         mid_occ_ff <= mid_occ_in;
         out_occ_ff <= out_occ_in;
      end
   end

   // ---------------------------------------------------------------
   // front: offset add and matrix rows -> clip word
   // ---------------------------------------------------------------
   logic               front_valid;
   wtsp_pkg::clip_type front_clip, mid_clip;

   wtsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take),
      .in_word   (req_word),
      .matrix    (matrix),
      .out_valid (front_valid),
      .out_clip  (front_clip)
   );

   wtsp_fifo #(
      .WIDTH ($bits(wtsp_pkg::clip_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .data_in  (front_clip),
      .pop      (mid_take),
      .empty    (mid_empty),
      .data_out (mid_clip)
   );

   // ---------------------------------------------------------------
   // back: visibility test, viewport scaling and pixel divide
   // ---------------------------------------------------------------
   logic                   back_valid;
   wtsp_pkg::rsp_word_type back_word;

   wtsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_take),
      .in_clip   (mid_clip),
      .viewport  (viewport),
      .out_valid (back_valid),
      .out_word  (back_word)
   );

   wtsp_fifo #(
      .WIDTH ($bits(wtsp_pkg::rsp_word_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (back_valid),
      .data_in  (back_word),
      .pop      (rsp_take),
      .empty    (empty),
      .data_out (rsp_word)
   );

endmodule

/* verif/world_to_screen_projection_tb.sv */
`timescale 1ns / 100ps

module world_to_screen_projection_tb;
   import wtsp_pkg::*;

   // clock, reset and ports of the block
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   req_word_type req_word = '0;
   logic empty;
   logic pop = 1'b0;
   rsp_word_type rsp_word;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   world_to_screen_projection DUT (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_word(req_word),
      .empty(empty), .pop(pop), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   // shadow copy of the block's registers, kept in step with every csr write
   logic [REG_W-1:0]  coef_shadow [6];
   logic [SIZE_W-1:0] width_shadow;
   logic [SIZE_W-1:0] height_shadow;

   // projected words still owed by the block, oldest first
   rsp_word_type pending_pixels[$];
   int mismatches = 0;

   // idling percentages of the two sides, and the long receiver hold-off
   int tx_idle = 0;
   int rx_idle = 0;
   logic hold_req = 1'b0;
   logic hold_rx = 1'b0;

   // directed table: a word plus, where obvious, its typed-in result
   typedef struct {
      req_word_type w;
      bit           known;
      rsp_word_type exp;
   } stim_row_type;
   stim_row_type directed[$];

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // one matrix row dotted with (x, y, z, 1); 32 fraction bits, exact
   function automatic logic signed [127:0] row_dot(input int r,
         input logic signed [127:0] x, input logic signed [127:0] y,
         input logic signed [127:0] z);
      logic signed [127:0] c0, c1, c2, c3;
      c0 = $signed(coef_shadow[2*r][COEF_W-1:0]);
      c1 = $signed(coef_shadow[2*r][REG_W-1:COEF_W]);
      c2 = $signed(coef_shadow[2*r+1][COEF_W-1:0]);
      c3 = $signed(coef_shadow[2*r+1][REG_W-1:COEF_W]);
      return c0 * x + c1 * y + c2 * z + (c3 <<< FRAC_W);
   endfunction

   // trunc(n * size / d) toward zero, clamped to 16 bits; d > 0
   function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [127:0] n,
         input logic [SIZE_W-1:0] size, input logic signed [127:0] d);
      logic [127:0] mag, num, q;
      logic neg;
      neg = n < 0;
      mag = neg ? -n : n;
      num = mag * {114'd0, size};
      q = num / d;
      if (neg) begin
         if (q > 128'd32768) q = 128'd32768;
         return -q[PIX_W-1:0];
      end
      if (q > 128'd32767) q = 128'd32767;
      return q[PIX_W-1:0];
   endfunction

   function automatic rsp_word_type project(input req_word_type r);
      logic signed [127:0] x, y, z, w, sx, sy;
      rsp_word_type o;
      x = $signed(r.pos_x) + $signed(r.off_x);
      y = $signed(r.pos_y) + $signed(r.off_y);
      z = $signed(r.pos_z) + $signed(r.off_z);
      w = row_dot(2, x, y, z);
      o = '0;
      // behind the eye: w at or below the threshold gives an all-zero word
      if (w <= (128'sd66 <<< FRAC_W)) return o;
      sx = row_dot(0, x, y, z);
      sy = row_dot(1, x, y, z);
      o.on_screen = 1'b1;
      o.screen_x = to_pixel(w + sx, width_shadow, w + w);
      o.screen_y = to_pixel(w - sy, height_shadow, w + w);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(8 * int'(idx)); pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (int'(idx) < 6) coef_shadow[int'(idx)] = v[REG_W-1:0];
      else if (idx == REG_WIDTH) width_shadow = v[SIZE_W-1:0];
      else height_shadow = v[SIZE_W-1:0];
   endtask

   // offer one word; push stays high across back-to-back words
   task automatic send_word(input req_word_type w, input bit known, input rsp_word_type exp);
      while ($urandom_range(99) < tx_idle) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_pixels.push_back(known ? exp : project(w));
      @(negedge clock);
   endtask

   // block drained, plus room for anything still in flight
   task automatic drain;
      push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord;
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;  // +-8.0
         2: case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef;
      if ($urandom_range(2) == 0) return COEF_W'($urandom);
      return COEF_W'($urandom_range(32'h0004_0000) - 32'h0002_0000);  // +-2.0
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_row_pair;
      return {16'd0, rand_coef(), rand_coef()};
   endfunction

   task automatic send_random(input int count);
      req_word_type w;
      for (int i = 0; i < count; i++) begin
         w.pos_x = rand_coord(); w.pos_y = rand_coord(); w.pos_z = rand_coord();
         w.off_x = rand_coord(); w.off_y = rand_coord(); w.off_z = rand_coord();
         send_word(w, 1'b0, '0);
      end
   endtask

   function automatic stim_row_type row(input logic [31:0] px, input logic [31:0] py,
         input logic [31:0] pz, input logic [31:0] ox, input logic [31:0] oy,
         input bit known, input logic signed [15:0] ex, input logic signed [15:0] ey);
      stim_row_type s;
      s.w = {px, py, pz, ox, oy, 32'd0};
      s.known = known;
      s.exp = {1'b1, ex, ey};
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // receiver and checker
   // ---------------------------------------------------------------------

   always @(negedge clock) pop <= !hold_rx && ($urandom_range(99) >= rx_idle);

   // long stall on the result side, counted here in its own process
   initial begin
      wait (hold_req);
      @(negedge clock) hold_rx <= 1'b1;
      repeat (400) @(negedge clock);
      hold_rx <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", rsp_word);
         end else begin
            if (rsp_word !== pending_pixels[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp on=%0d x=%0d y=%0d, got on=%0d x=%0d y=%0d",
                     pending_pixels[0].on_screen, pending_pixels[0].screen_x,
                     pending_pixels[0].screen_y, rsp_word.on_screen,
                     rsp_word.screen_x, rsp_word.screen_y);
            end
            void'(pending_pixels.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequence of phases
   // ---------------------------------------------------------------------

   initial begin
      // reset values mirrored: identity rows, 1920 x 1080
      coef_shadow[0] = 48'h1 << FRAC_W;
      coef_shadow[1] = '0;
      coef_shadow[2] = 48'h1 << (FRAC_W + COEF_W);
      coef_shadow[3] = '0;
      coef_shadow[4] = '0;
      coef_shadow[5] = 48'h1 << (FRAC_W + COEF_W);
      width_shadow = 14'd1920;
      height_shadow = 14'd1080;

      // with identity rows w is 1.0: x = (1+px)*960, y = (1-py)*540
      directed.push_back(row(0, 0, 0, 0, 0, 1, 960, 540));
      directed.push_back(row(32'h7fffffff, 0, 0, 32'h7fffffff, 0, 1, 32767, 540));
      directed.push_back(row(32'h80000000, 0, 0, 32'h80000000, 0, 1, -32768, 540));
      directed.push_back(row(0, 32'h10000, 0, 0, 0, 1, 960, 0));
      directed.push_back(row(0, 32'hffff0000, 0, 0, 0, 1, 960, 1080));
      directed.push_back(row(32'hffff0000, 0, 0, 0, 0, 1, 0, 540));
      directed.push_back(row(32'h10000, 0, 0, 0, 0, 1, 1920, 540));
      directed.push_back(row(0, 0, 32'h7fffffff, 0, 0, 1, 960, 540));
      directed.push_back(row(0, 0, 32'h80000000, 0, 0, 1, 960, 540));
      directed.push_back(row(0, 32'h7fffffff, 0, 0, 32'h7fffffff, 1, 960, -32768));
      directed.push_back(row(32'hffffffff, 32'hffffffff, 32'hffffffff,
                             32'hffffffff, 32'hffffffff, 0, 0, 0));
      directed.push_back(row(32'h00008000, 32'h12345678, 32'h0, 32'h0, 32'h0, 0, 0, 0));

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // phase 1: reset settings, directed rows then random words, sender 23 / receiver 54
      tx_idle = 23; rx_idle = 54;
      foreach (directed[i]) send_word(directed[i].w, directed[i].known, directed[i].exp);
      send_random(200);
      drain();

      // phase 2: random matrix, widest viewport, roles swapped
      tx_idle = 54; rx_idle = 23;
      for (int i = 0; i < 6; i++) csr_write(csr_index_type'(i), rand_row_pair());
      csr_write(REG_WIDTH, 8192);
      csr_write(REG_HEIGHT, 1);
      send_random(250);
      drain();

      // phase 3: perspective rows (w = z), no idling, long result stall
      tx_idle = 0; rx_idle = 0;
      csr_write(REG_ROW0_XY, {16'd0, rand_coef(), 24'h010000});
      csr_write(REG_ROW0_ZW, {16'd0, rand_coef(), rand_coef()});
      csr_write(REG_ROW1_XY, {16'd0, 24'h010000, rand_coef()});
      csr_write(REG_ROW1_ZW, rand_row_pair());
      csr_write(REG_ROW3_XY, {16'd0, 48'd0});
      csr_write(REG_ROW3_ZW, {16'd0, 24'h000000, 24'h010000});
      csr_write(REG_WIDTH, 1);
      csr_write(REG_HEIGHT, 8192);
      hold_req = 1'b1;
      send_random(300);
      drain();

      // phase 4: extreme coefficients, zero width, height above 8192
      tx_idle = 23; rx_idle = 54;
      csr_write(REG_ROW0_XY, 64'h0000_7fffff_800000);
      csr_write(REG_ROW0_ZW, 64'h0000_800000_7fffff);
      csr_write(REG_ROW1_XY, 64'h0000_ffffff_ffffff);
      csr_write(REG_ROW1_ZW, rand_row_pair());
      csr_write(REG_ROW3_XY, rand_row_pair());
      csr_write(REG_ROW3_ZW, rand_row_pair());
      csr_write(REG_WIDTH, 0);
      csr_write(REG_HEIGHT, 16383);
      send_random(250);
      drain();

      // phase 5: w row cleared, every point behind the eye
      tx_idle = 54; rx_idle = 23;
      csr_write(REG_ROW3_XY, 0);
      csr_write(REG_ROW3_ZW, 0);
      send_random(60);
      drain();

      // phase 6: random everything, no idling
      tx_idle = 0; rx_idle = 0;
      for (int i = 0; i < 6; i++) csr_write(csr_index_type'(i), rand_row_pair());
      csr_write(REG_WIDTH, $urandom_range(8192, 1));
      csr_write(REG_HEIGHT, $urandom_range(8192, 1));
      send_random(200);
      drain();

      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("PASS world_to_screen_projection");
      else
         $display("FAIL world_to_screen_projection");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #5ms;
      $display("FAIL world_to_screen_projection");
      $finish;
   end

endmodule
